>>> design/rmtc_pkg.sv
// ----------------------------------------------------------------------------
// rmtc_pkg
// Shared widths, constants and cell data types for the true course solver.
// ----------------------------------------------------------------------------
package rmtc_pkg;

   localparam int XW = 34;   // sine/cosine datapath, Q30 with headroom
   localparam int VW = 40;   // velocity vector datapath, Q16 hundredths of a knot
   localparam int AW = 32;   // phase, one turn is 2^32
   localparam int DW = 33;   // divisor (2025372 * minutes)
   localparam int RW = 34;   // divider partial remainder
   localparam int QW = 36;   // quotient bits
   localparam int NW = 57;   // scaled dividend
   localparam int TAB_LEN = 30;

   localparam logic signed [XW-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [15:0] FULL_TURN = 16'd36000;
   localparam logic [13:0] MAX_SPEED = 14'd9999;

   localparam logic [AW-1:0] ATAN_TAB [TAB_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [XW-1:0] z;
   } rot_type;

   typedef struct packed {
      logic signed [VW-1:0] x;
      logic signed [VW-1:0] y;
      logic [AW-1:0]        z;
   } vec_type;

   typedef struct packed {
      logic [RW-1:0] rem;
      logic [QW-1:0] nlo;
      logic [QW-1:0] quo;
      logic [DW-1:0] den;
   } div_type;

endpackage

>>> design/rmtc_rot_cell.sv
// ----------------------------------------------------------------------------
// rmtc_rot_cell
// One rotation-mode CORDIC iteration, registered.
// ----------------------------------------------------------------------------
module rmtc_rot_cell #(
   parameter int STEP = 0
) (
   input  logic             clock,
   input  logic             en,
   input  rmtc_pkg::rot_type d_i,
   output rmtc_pkg::rot_type d_o
);

   rmtc_pkg::rot_type d_ff, d_in;
   logic signed [rmtc_pkg::XW-1:0] dx, dy, ang;

   always_comb begin
      dx  = d_i.y >>> STEP;
      dy  = d_i.x >>> STEP;
      ang = $signed({{(rmtc_pkg::XW-rmtc_pkg::AW){1'b0}}, rmtc_pkg::ATAN_TAB[STEP]});
      if (d_i.z >= 0) begin
         d_in.x = d_i.x - dx;
         d_in.y = d_i.y + dy;
         d_in.z = d_i.z - ang;
      end else begin
         d_in.x = d_i.x + dx;
         d_in.y = d_i.y - dy;
         d_in.z = d_i.z + ang;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in;
      end
   end

   assign d_o = d_ff;

endmodule

>>> design/rmtc_vec_cell.sv
// ----------------------------------------------------------------------------
// rmtc_vec_cell
// One vectoring-mode CORDIC iteration, registered.
// ----------------------------------------------------------------------------
module rmtc_vec_cell #(
   parameter int STEP = 0
) (
   input  logic             clock,
   input  logic             en,
   input  rmtc_pkg::vec_type d_i,
   output rmtc_pkg::vec_type d_o
);

   rmtc_pkg::vec_type d_ff, d_in;
   logic signed [rmtc_pkg::VW-1:0] dx, dy;

   always_comb begin
      dx = d_i.y >>> STEP;
      dy = d_i.x >>> STEP;
      if (d_i.y >= 0) begin
         d_in.x = d_i.x + dx;
         d_in.y = d_i.y - dy;
         d_in.z = d_i.z + rmtc_pkg::ATAN_TAB[STEP];
      end else begin
         d_in.x = d_i.x - dx;
         d_in.y = d_i.y + dy;
         d_in.z = d_i.z - rmtc_pkg::ATAN_TAB[STEP];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in;
      end
   end

   assign d_o = d_ff;

endmodule

>>> design/rmtc_div_cell.sv
// ----------------------------------------------------------------------------
// rmtc_div_cell
// One restoring-division step: brings down a dividend bit, yields a quotient bit.
// ----------------------------------------------------------------------------
module rmtc_div_cell (
   input  logic             clock,
   input  logic             en,
   input  rmtc_pkg::div_type d_i,
   output rmtc_pkg::div_type d_o
);

   rmtc_pkg::div_type d_ff, d_in;
   logic [rmtc_pkg::RW-1:0] trial;
   logic                    ge;

   always_comb begin
      // remainder stays below the divisor, so its top bit is always clear
      trial     = {d_i.rem[rmtc_pkg::RW-2:0], d_i.nlo[rmtc_pkg::QW-1]};
      ge        = trial >= {1'b0, d_i.den};
      d_in.rem  = ge ? trial - {1'b0, d_i.den} : trial;
      d_in.nlo  = {d_i.nlo[rmtc_pkg::QW-2:0], 1'b0};
      d_in.quo  = {d_i.quo[rmtc_pkg::QW-2:0], ge};
      d_in.den  = d_i.den;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= d_in;
      end
   end

   assign d_o = d_ff;

endmodule

>>> design/relative_motion_true_course_solver_unit.sv
// ----------------------------------------------------------------------------
// relative_motion_true_course_solver_unit
// Maneuvering-board solver: two contact fixes plus own motion to true course
// and speed of the contact.
// ----------------------------------------------------------------------------
// A fully pipelined datapath: one request is taken every cycle unless a
// finished result is stalled at the output. Each result passes through the
// two chains of CORDIC cells (bearing sine/cosine, then course/magnitude) and
// the 36-cell division chain that turns displacement into speed. The whole
// pipeline advances in lock step and holds while a finished result sits
// stalled in the output register, so req_stall simply follows rsp_valid &&
// rsp_stall. A zero interval flags an error and returns zero course and
// speeds.
module relative_motion_true_course_solver_unit #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_own_course,
   input  logic [13:0] req_own_speed,
   input  logic [15:0] req_first_bearing,
   input  logic [15:0] req_first_range,
   input  logic [15:0] req_second_bearing,
   input  logic [15:0] req_second_range,
   input  logic [10:0] req_elapsed_minutes,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_true_course,
   output logic [13:0] rsp_true_speed,
   output logic [13:0] rsp_relative_speed,
   output logic        rsp_error_flag
);

   localparam int XW = rmtc_pkg::XW;
   localparam int VW = rmtc_pkg::VW;
   localparam int QW = rmtc_pkg::QW;

   typedef struct packed {
      logic        valid;
      logic [15:0] r1;
      logic [15:0] r2;
      logic [13:0] spd;
      logic [10:0] mins;
   } front_type;

   typedef struct packed {
      logic        valid;
      logic        err;
      logic        sgn_e;
      logic        sgn_n;
      logic [31:0] own_e;
      logic [31:0] own_n;
   } mid_type;

   typedef struct packed {
      logic valid;
      logic err;
      logic rel_zero;
      logic true_zero;
   } back_type;

   logic en;

   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // ---------------- angle to phase ----------------
   logic [15:0] ang [3];
   logic [31:0] s1_hi_in [3];
   logic [29:0] s1_n_in  [3];
   logic [31:0] s1_hi_ff [3], s2_hi_ff [3], s3_hi_ff [3];
   logic [29:0] s1_n_ff  [3], s2_n_ff  [3], s3_n_ff  [3];
   logic [14:0] s2_qe_in [3], s2_qe_ff [3], s3_qe_ff [3];
   logic [29:0] s3_pq_ff [3];
   logic [46:0] qe_prod  [3];
   front_type   s1_side_ff, s2_side_ff, s3_side_ff;
   front_type   side_rot_ff [CORDIC_STEPS+1];
   rmtc_pkg::rot_type rot_in [3];
   rmtc_pkg::rot_type rot_in_ff [3];
   rmtc_pkg::rot_type rot_d [3][CORDIC_STEPS+1];

   assign ang[0] = req_first_bearing;
   assign ang[1] = req_second_bearing;
   assign ang[2] = req_own_course;

   always_comb begin
      logic [15:0] am;
      for (int k = 0; k < 3; k++) begin
         am = (ang[k] >= rmtc_pkg::FULL_TURN) ? ang[k] - rmtc_pkg::FULL_TURN : ang[k];
         // 2^32 = 36000 * 119304 + 23296
         s1_hi_in[k] = 32'(am) * 32'd119304;
         s1_n_in[k]  = 30'(am) * 30'd23296 + 30'd18000;
         qe_prod[k]  = {17'd0, s1_n_ff[k]} * 47'd119305;
         s2_qe_in[k] = qe_prod[k][46:32];
      end
   end

   always_comb begin
      logic [14:0]          q;
      logic [31:0]          ph;
      logic signed [XW-1:0] zv;
      for (int k = 0; k < 3; k++) begin
         // reciprocal estimate is at most one high
         q  = s3_qe_ff[k] - ((s3_n_ff[k] < s3_pq_ff[k]) ? 15'd1 : 15'd0);
         ph = s3_hi_ff[k] + {17'd0, q};
         zv = $signed({{(XW-32){ph[31]}}, ph});
         rot_in[k].y = '0;
         if (zv > $signed(34'sh040000000)) begin
            rot_in[k].z = zv - $signed(34'sh080000000);
            rot_in[k].x = -rmtc_pkg::CORDIC_GAIN;
         end else if (zv < -$signed(34'sh040000000)) begin
            rot_in[k].z = zv + $signed(34'sh080000000);
            rot_in[k].x = -rmtc_pkg::CORDIC_GAIN;
         end else begin
            rot_in[k].z = zv;
            rot_in[k].x = rmtc_pkg::CORDIC_GAIN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff.valid <= 1'b0;
         s2_side_ff.valid <= 1'b0;
         s3_side_ff.valid <= 1'b0;
         for (int j = 0; j <= CORDIC_STEPS; j++) begin
            side_rot_ff[j].valid <= 1'b0;
         end
      end else if (en) begin
         s1_side_ff <= '{valid: req_valid, r1: req_first_range, r2: req_second_range,
                         spd: req_own_speed, mins: req_elapsed_minutes};
         s2_side_ff <= s1_side_ff;
         s3_side_ff <= s2_side_ff;
         side_rot_ff[0] <= s3_side_ff;
         for (int j = 1; j <= CORDIC_STEPS; j++) begin
            side_rot_ff[j] <= side_rot_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            s1_hi_ff[k]  <= s1_hi_in[k];
            s1_n_ff[k]   <= s1_n_in[k];
            s2_hi_ff[k]  <= s1_hi_ff[k];
            s2_n_ff[k]   <= s1_n_ff[k];
            s2_qe_ff[k]  <= s2_qe_in[k];
            s3_hi_ff[k]  <= s2_hi_ff[k];
            s3_n_ff[k]   <= s2_n_ff[k];
            s3_qe_ff[k]  <= s2_qe_ff[k];
            s3_pq_ff[k]  <= 30'(s2_qe_ff[k]) * 30'd36000;
            rot_in_ff[k] <= rot_in[k];
         end
      end
   end

   // ---------------- sine/cosine chains ----------------
   for (genvar k = 0; k < 3; k++) begin : g_rot_lane
      assign rot_d[k][0] = rot_in_ff[k];
      for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_rot
         rmtc_rot_cell #(.STEP(j)) u_cell (
            .clock (clock),
            .en    (en),
            .d_i   (rot_d[k][j]),
            .d_o   (rot_d[k][j+1])
         );
      end
   end

   // ---------------- displacement and own velocity ----------------
   logic signed [50:0] s5_pe1_ff, s5_pe2_ff, s5_pn1_ff, s5_pn2_ff;
   logic signed [48:0] s5_poe_ff, s5_pon_ff;
   front_type          s5_side_ff;
   logic signed [51:0] diff_e, diff_n;
   logic [XW-1:0]      s6_de_ff, s6_dn_ff;
   logic [rmtc_pkg::DW-1:0] s6_den_ff;
   mid_type            s6_side_ff;
   logic [XW-1:0]      mag_e, mag_n;
   rmtc_pkg::div_type  div_in [2];
   rmtc_pkg::div_type  div_in_ff [2];
   rmtc_pkg::div_type  div_d [2][QW+1];
   mid_type            side_div_ff [QW+1];
   logic [rmtc_pkg::NW-1:0] num [2];

   always_comb begin
      diff_e = {s5_pe2_ff[50], s5_pe2_ff} - {s5_pe1_ff[50], s5_pe1_ff};
      diff_n = {s5_pn2_ff[50], s5_pn2_ff} - {s5_pn1_ff[50], s5_pn1_ff};
      mag_e  = s6_de_ff[XW-1] ? XW'(-s6_de_ff) : s6_de_ff;
      mag_n  = s6_dn_ff[XW-1] ? XW'(-s6_dn_ff) : s6_dn_ff;
      num[0] = {23'd0, mag_e} * 57'd6000000;
      num[1] = {23'd0, mag_n} * 57'd6000000;
      for (int l = 0; l < 2; l++) begin
         // top dividend bits are below 2^20, already under any nonzero divisor
         div_in[l].rem = {13'd0, num[l][56:36]};
         div_in[l].nlo = num[l][35:0];
         div_in[l].quo = '0;
         div_in[l].den = s6_den_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s5_pe1_ff <= $signed({1'b0, side_rot_ff[CORDIC_STEPS].r1}) * rot_d[0][CORDIC_STEPS].y;
         s5_pn1_ff <= $signed({1'b0, side_rot_ff[CORDIC_STEPS].r1}) * rot_d[0][CORDIC_STEPS].x;
         s5_pe2_ff <= $signed({1'b0, side_rot_ff[CORDIC_STEPS].r2}) * rot_d[1][CORDIC_STEPS].y;
         s5_pn2_ff <= $signed({1'b0, side_rot_ff[CORDIC_STEPS].r2}) * rot_d[1][CORDIC_STEPS].x;
         s5_poe_ff <= $signed({1'b0, side_rot_ff[CORDIC_STEPS].spd}) * rot_d[2][CORDIC_STEPS].y;
         s5_pon_ff <= $signed({1'b0, side_rot_ff[CORDIC_STEPS].spd}) * rot_d[2][CORDIC_STEPS].x;
         s6_de_ff  <= diff_e[47:14];
         s6_dn_ff  <= diff_n[47:14];
         s6_den_ff <= 33'(s5_side_ff.mins) * 33'd2025372;
         div_in_ff[0] <= div_in[0];
         div_in_ff[1] <= div_in[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s5_side_ff.valid <= 1'b0;
         s6_side_ff.valid <= 1'b0;
         for (int j = 0; j <= QW; j++) begin
            side_div_ff[j].valid <= 1'b0;
         end
      end else if (en) begin
         s5_side_ff <= side_rot_ff[CORDIC_STEPS];
         s6_side_ff <= '{valid: s5_side_ff.valid, err: (s5_side_ff.mins == 11'd0),
                         sgn_e: 1'b0, sgn_n: 1'b0,
                         own_e: s5_poe_ff[45:14], own_n: s5_pon_ff[45:14]};
         side_div_ff[0] <= '{valid: s6_side_ff.valid, err: s6_side_ff.err,
                             sgn_e: s6_de_ff[XW-1], sgn_n: s6_dn_ff[XW-1],
                             own_e: s6_side_ff.own_e, own_n: s6_side_ff.own_n};
         for (int j = 1; j <= QW; j++) begin
            side_div_ff[j] <= side_div_ff[j-1];
         end
      end
   end

   // ---------------- division chains ----------------
   for (genvar l = 0; l < 2; l++) begin : g_div_lane
      assign div_d[l][0] = div_in_ff[l];
      for (genvar j = 0; j < QW; j++) begin : g_div
         rmtc_div_cell u_cell (
            .clock (clock),
            .en    (en),
            .d_i   (div_d[l][j]),
            .d_o   (div_d[l][j+1])
         );
      end
   end

   // ---------------- vectors into polar form ----------------
   logic signed [VW-1:0] rel_e, rel_n, tru_e, tru_n;
   rmtc_pkg::vec_type    vec_in [2];
   rmtc_pkg::vec_type    vec_in_ff [2];
   rmtc_pkg::vec_type    vec_d [2][CORDIC_STEPS+1];
   back_type             side_vec_ff [CORDIC_STEPS+1];
   back_type             back_in;
   mid_type              mside;

   always_comb begin
      logic [QW:0] qe, qn;
      mside = side_div_ff[QW];
      qe    = {1'b0, div_d[0][QW].quo};
      qn    = {1'b0, div_d[1][QW].quo};
      rel_e = $signed({{(VW-QW-1){1'b0}}, mside.sgn_e ? (QW+1)'(-qe) : qe});
      rel_n = $signed({{(VW-QW-1){1'b0}}, mside.sgn_n ? (QW+1)'(-qn) : qn});
      if (mside.sgn_e) rel_e = $signed({{(VW-QW-1){rel_e[QW]}}, rel_e[QW:0]});
      if (mside.sgn_n) rel_n = $signed({{(VW-QW-1){rel_n[QW]}}, rel_n[QW:0]});
      tru_e = rel_e + $signed({{(VW-32){mside.own_e[31]}}, mside.own_e});
      tru_n = rel_n + $signed({{(VW-32){mside.own_n[31]}}, mside.own_n});
      vec_in[0] = '{x: rel_n, y: rel_e, z: '0};
      vec_in[1] = '{x: tru_n, y: tru_e, z: '0};
      for (int l = 0; l < 2; l++) begin
         // fold the left half plane over by half a turn
         if (vec_in[l].x < 0) begin
            vec_in[l].x = -vec_in[l].x;
            vec_in[l].y = -vec_in[l].y;
            vec_in[l].z = 32'h80000000;
         end
      end
      back_in = '{valid: mside.valid, err: mside.err,
                  rel_zero: (rel_n == 0) && (rel_e == 0),
                  true_zero: (tru_n == 0) && (tru_e == 0)};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec_in_ff[0] <= vec_in[0];
         vec_in_ff[1] <= vec_in[1];
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_vec_lane
      assign vec_d[l][0] = vec_in_ff[l];
      for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_vec
         rmtc_vec_cell #(.STEP(j)) u_cell (
            .clock (clock),
            .en    (en),
            .d_i   (vec_d[l][j]),
            .d_o   (vec_d[l][j+1])
         );
      end
   end

   // ---------------- course and speed scaling ----------------
   logic [47:0] s9_cp_ff;
   logic [50:0] s9_mr_ff, s9_mt_ff;
   logic        s9_rel_sat_ff, s9_rel_zero_ff, s9_tru_sat_ff, s9_tru_zero_ff;
   back_type    s9_side_ff;
   logic [15:0] crs;
   logic [50:0] mr_sum, mt_sum;
   logic [14:0] mr, mt;
   logic [15:0] crs_fix;
   logic [13:0] spd_rel, spd_tru;
   logic [47:0] cp_sum;
   logic signed [VW-1:0] xr, xt;

   assign xr = vec_d[0][CORDIC_STEPS].x;
   assign xt = vec_d[1][CORDIC_STEPS].x;

   always_ff @(posedge clock) begin
      if (en) begin
         s9_cp_ff       <= {16'd0, vec_d[1][CORDIC_STEPS].z} * 48'd36000;
         s9_mr_ff       <= {20'd0, xr[30:0]} * 51'd636751;
         s9_mt_ff       <= {20'd0, xt[30:0]} * 51'd636751;
         // beyond 2^31 the scaled magnitude is far past the speed limit
         s9_rel_sat_ff  <= !xr[VW-1] && (xr[VW-2:31] != '0);
         s9_tru_sat_ff  <= !xt[VW-1] && (xt[VW-2:31] != '0);
         s9_rel_zero_ff <= (xr <= 0) || side_vec_ff[CORDIC_STEPS].rel_zero;
         s9_tru_zero_ff <= (xt <= 0) || side_vec_ff[CORDIC_STEPS].true_zero;
      end
   end

   always_comb begin
      cp_sum  = s9_cp_ff + 48'h000080000000;
      crs     = cp_sum[47:32];
      crs_fix = (crs >= rmtc_pkg::FULL_TURN) ? 16'd0 : crs;
      mr_sum  = s9_mr_ff + 51'h00800000000;
      mt_sum  = s9_mt_ff + 51'h00800000000;
      mr      = mr_sum[50:36];
      mt      = mt_sum[50:36];
      spd_rel = (s9_rel_sat_ff || (mr > 15'(rmtc_pkg::MAX_SPEED))) ? rmtc_pkg::MAX_SPEED
                                                                  : mr[13:0];
      spd_tru = (s9_tru_sat_ff || (mt > 15'(rmtc_pkg::MAX_SPEED))) ? rmtc_pkg::MAX_SPEED
                                                                  : mt[13:0];
   end

   logic        rsp_valid_ff;
   logic [15:0] rsp_course_ff;
   logic [13:0] rsp_tspd_ff, rsp_rspd_ff;
   logic        rsp_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= CORDIC_STEPS; j++) begin
            side_vec_ff[j].valid <= 1'b0;
         end
         s9_side_ff.valid <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else if (en) begin
         side_vec_ff[0] <= back_in;
         for (int j = 1; j <= CORDIC_STEPS; j++) begin
            side_vec_ff[j] <= side_vec_ff[j-1];
         end
         s9_side_ff   <= side_vec_ff[CORDIC_STEPS];
         rsp_valid_ff <= s9_side_ff.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_err_ff    <= s9_side_ff.err;
         rsp_course_ff <= (s9_side_ff.err || s9_tru_zero_ff) ? 16'd0 : crs_fix;
         rsp_tspd_ff   <= (s9_side_ff.err || s9_tru_zero_ff) ? 14'd0 : spd_tru;
         rsp_rspd_ff   <= (s9_side_ff.err || s9_rel_zero_ff) ? 14'd0 : spd_rel;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_true_course    = rsp_course_ff;
   assign rsp_true_speed     = rsp_tspd_ff;
   assign rsp_relative_speed = rsp_rspd_ff;
   assign rsp_error_flag     = rsp_err_ff;

endmodule

>>> design/rmtc_checker.sv
// ----------------------------------------------------------------------------
// rmtc_checker
// Port-level checks on the solver's request and result channels.
// ----------------------------------------------------------------------------
module rmtc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_true_course,
   input logic [13:0] rsp_true_speed,
   input logic [13:0] rsp_relative_speed,
   input logic        rsp_error_flag
);

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_true_course)
         && $stable(rsp_true_speed) && $stable(rsp_relative_speed)
         && $stable(rsp_error_flag))
      else $error("stalled result changed");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a stalled result");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_flag |-> rsp_true_course == 16'd0
         && rsp_true_speed == 14'd0 && rsp_relative_speed == 14'd0)
      else $error("error result not zeroed");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_true_course < 16'd36000 && rsp_true_speed <= 14'd9999
         && rsp_relative_speed <= 14'd9999)
      else $error("result out of range");

endmodule

bind relative_motion_true_course_solver_unit rmtc_checker u_rmtc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_true_course    (rsp_true_course),
   .rsp_true_speed     (rsp_true_speed),
   .rsp_relative_speed (rsp_relative_speed),
   .rsp_error_flag     (rsp_error_flag)
);

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the true course solver. Requests are driven on the
// falling edge and results sampled on the rising edge. Expected course and
// speeds come from a fixed-point model of the bearing/range solution kept in
// a small scoreboard. The run walks through several idle and stall mixes,
// including a long output hold and a full drain.
// ----------------------------------------------------------------------------
module testbench;

   localparam int STEPS = 16;
   localparam longint unsigned YARD_SCALE = 2025372;

   typedef struct {
      logic [15:0] own_course;
      logic [13:0] own_speed;
      logic [15:0] first_bearing;
      logic [15:0] first_range;
      logic [15:0] second_bearing;
      logic [15:0] second_range;
      logic [10:0] elapsed_minutes;
   } fix_pair_type;

   typedef struct {
      logic [15:0] true_course;
      logic [13:0] true_speed;
      logic [13:0] relative_speed;
      logic        error_flag;
   } solution_type;

   class solution_scoreboard;
      solution_type expected_q[$];
      int errors;
      int solved;

      function void bearing_sin_cos(input int unsigned ang, output longint sn,
                                    output longint cs);
         longint unsigned ph;
         longint z, x, y, dx, dy;
         ang = ang % 36000;
         ph = ((longint'(ang) << 32) + 18000) / 36000;
         x = 652032874;
         y = 0;
         z = (ph < 64'h80000000) ? longint'(ph) : longint'(ph) - 64'sh100000000;
         if (z > 64'sh40000000) begin
            z -= 64'sh80000000;
            x = -652032874;
         end else if (z < -64'sh40000000) begin
            z += 64'sh80000000;
            x = -652032874;
         end
         for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= longint'(rmtc_pkg::ATAN_TAB[i]);
            end else begin
               x += dx; y -= dy; z += longint'(rmtc_pkg::ATAN_TAB[i]);
            end
         end
         sn = y;
         cs = x;
      endfunction

      function void course_and_speed(input longint north, input longint east,
                                     output logic [15:0] crs, output logic [13:0] spd);
         longint x, y, dx, dy;
         bit [31:0] z;
         longint unsigned c, m;
         if (north == 0 && east == 0) begin
            crs = 0;
            spd = 0;
            return;
         end
         x = north;
         y = east;
         z = 0;
         if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h80000000;
         end
         for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx; y -= dy; z += rmtc_pkg::ATAN_TAB[i];
            end else begin
               x -= dx; y += dy; z -= rmtc_pkg::ATAN_TAB[i];
            end
         end
         c = ({32'b0, z} * 64'd36000 + 64'h80000000) >> 32;
         if (c >= 36000) c = 0;
         if (x <= 0) begin
            m = 0;
         end else begin
            m = (longint'(x) * 64'd636751 + (64'd1 << 35)) >> 36;
            if (m > 9999) m = 9999;
         end
         crs = c[15:0];
         spd = m[13:0];
      endfunction

      function void note_request(fix_pair_type r);
         solution_type s;
         longint s1, c1, s2, c2, so, co, de, dn, den, re, rn;
         logic [15:0] unused_course;
         s = '{default: 0};
         if (r.elapsed_minutes == 0) begin
            s.error_flag = 1'b1;
         end else begin
            bearing_sin_cos(32'(r.first_bearing), s1, c1);
            bearing_sin_cos(32'(r.second_bearing), s2, c2);
            bearing_sin_cos(32'(r.own_course), so, co);
            de = (longint'(r.second_range) * s2 - longint'(r.first_range) * s1) >>> 14;
            dn = (longint'(r.second_range) * c2 - longint'(r.first_range) * c1) >>> 14;
            den = longint'(YARD_SCALE) * longint'(r.elapsed_minutes);
            re = de * 64'sd6000000 / den;
            rn = dn * 64'sd6000000 / den;
            course_and_speed(rn, re, unused_course, s.relative_speed);
            course_and_speed(((longint'(r.own_speed) * co) >>> 14) + rn,
                             ((longint'(r.own_speed) * so) >>> 14) + re,
                             s.true_course, s.true_speed);
         end
         expected_q.push_back(s);
      endfunction

      function void check_result(solution_type got);
         solution_type exp_s;
         if (expected_q.size() == 0) begin
            $error("result with no request outstanding");
            errors++;
            return;
         end
         exp_s = expected_q.pop_front();
         solved++;
         if (got.true_course !== exp_s.true_course) begin
            $error("true_course expected %0d got %0d", exp_s.true_course, got.true_course);
            errors++;
         end
         if (got.true_speed !== exp_s.true_speed) begin
            $error("true_speed expected %0d got %0d", exp_s.true_speed, got.true_speed);
            errors++;
         end
         if (got.relative_speed !== exp_s.relative_speed) begin
            $error("relative_speed expected %0d got %0d",
                   exp_s.relative_speed, got.relative_speed);
            errors++;
         end
         if (got.error_flag !== exp_s.error_flag) begin
            $error("error_flag expected %0d got %0d", exp_s.error_flag, got.error_flag);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_own_course;
   logic [13:0] req_own_speed;
   logic [15:0] req_first_bearing;
   logic [15:0] req_first_range;
   logic [15:0] req_second_bearing;
   logic [15:0] req_second_range;
   logic [10:0] req_elapsed_minutes;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_true_course;
   logic [13:0] rsp_true_speed;
   logic [13:0] rsp_relative_speed;
   logic        rsp_error_flag;

   solution_scoreboard board;
   int sender_idle_pct;
   int receiver_stall_pct;
   int hold_cycles;
   int sent;

   relative_motion_true_course_solver_unit dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #3000000;
      $display("DONE: errors detected");
      $finish;
   end

   // receiver: long hold first, otherwise random stall
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      solution_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.true_course = rsp_true_course;
         got.true_speed = rsp_true_speed;
         got.relative_speed = rsp_relative_speed;
         got.error_flag = rsp_error_flag;
         board.check_result(got);
      end
   end

   task automatic send_request(fix_pair_type r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_own_course <= r.own_course;
      req_own_speed <= r.own_speed;
      req_first_bearing <= r.first_bearing;
      req_first_range <= r.first_range;
      req_second_bearing <= r.second_bearing;
      req_second_range <= r.second_range;
      req_elapsed_minutes <= r.elapsed_minutes;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
      sent++;
      @(negedge clock);
   endtask

   task automatic go_quiet();
      req_valid <= 0;
      @(negedge clock);
   endtask

   task automatic drain();
      go_quiet();
      while (board.expected_q.size() != 0) @(negedge clock);
   endtask

   function automatic fix_pair_type random_fix();
      fix_pair_type r;
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) begin
         // full-width noise, angles past a full turn included
         r.own_course = 16'($urandom);
         r.own_speed = 14'($urandom);
         r.first_bearing = 16'($urandom);
         r.first_range = 16'($urandom);
         r.second_bearing = 16'($urandom);
         r.second_range = 16'($urandom);
         r.elapsed_minutes = 11'($urandom);
      end else begin
         // plausible plot: second fix near the first, so speeds stay in range
         r.own_course = 16'($urandom_range(35999));
         r.own_speed = 14'($urandom_range(9999));
         r.first_bearing = 16'($urandom_range(35999));
         r.first_range = 16'($urandom_range(40000));
         r.second_bearing = 16'((r.first_bearing + $urandom_range(4000) + 34000) % 36000);
         r.second_range = 16'(r.first_range + $urandom_range(4000) - 2000);
         if (r.first_range < 2000 && r.second_range > 60000) r.second_range = 16'd0;
         r.elapsed_minutes = 11'($urandom_range(1, 60));
         if (pick < 20) r.elapsed_minutes = 11'd0;
         else if (pick < 30) r.elapsed_minutes = 11'($urandom_range(2047));
      end
      return r;
   endfunction

   task automatic random_phase(int count, int idle_pct, int stall_pct);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      repeat (count) send_request(random_fix());
   endtask

   initial begin
      fix_pair_type d[$];
      board = new();
      reset = 1;
      req_valid = 0;
      rsp_stall = 0;
      req_own_course = 0;
      req_own_speed = 0;
      req_first_bearing = 0;
      req_first_range = 0;
      req_second_bearing = 0;
      req_second_range = 0;
      req_elapsed_minutes = 0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_cycles = 0;
      sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      d = '{
         '{0, 0, 0, 0, 0, 0, 0},                        // zero interval
         '{35999, 9999, 35999, 65535, 0, 65535, 0},     // zero interval, busy fields
         '{0, 0, 0, 0, 0, 0, 1},                        // nothing moves
         '{9000, 0, 4500, 1000, 4500, 1000, 6},         // zero relative, no own speed
         '{9000, 1500, 4500, 1000, 4500, 1000, 6},      // zero relative motion
         '{18000, 1000, 0, 1000, 0, 1500, 3},           // contact opens dead astern
         '{0, 1000, 0, 2000, 0, 1000, 3},               // closing, opposite own
         '{0, 500, 9000, 1000, 27000, 1000, 30},
         '{36000, 1000, 36000, 2000, 45000, 2000, 10},  // angles past a full turn
         '{65535, 16383, 65535, 3000, 65535, 3100, 5},
         '{35999, 9999, 35999, 65535, 0, 0, 1},         // speed saturates
         '{0, 0, 0, 0, 18000, 65535, 1},
         '{0, 0, 0, 65535, 0, 65535, 2047},
         '{27000, 2000, 13500, 12000, 14000, 11000, 1439},
         '{13500, 2500, 31500, 5000, 31000, 5200, 12},
         '{22500, 9999, 0, 8000, 100, 8000, 15},
         '{4500, 9999, 22500, 100, 22500, 0, 1},
         '{31500, 3000, 9000, 4000, 8900, 4100, 20},
         '{0, 16383, 0, 0, 0, 0, 2047},
         '{18000, 0, 27000, 2000, 9000, 2000, 60}
      };
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      foreach (d[i]) send_request(d[i]);

      random_phase(300, 0, 0);
      random_phase(250, 82, 0);
      random_phase(250, 0, 82);
      random_phase(250, 10, 10);

      // hold the output long enough that the pipeline backs up into the input
      hold_cycles = 400;
      random_phase(200, 0, 0);
      drain();
      random_phase(50, 0, 30);

      drain();
      repeat (2 * STEPS + 100) @(posedge clock);
      $display("covered %0d requests, %0d solutions checked across idle/stall mixes",
               sent, board.solved);
      if (board.errors == 0 && board.expected_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end
endmodule

>>> filelist.f
design/rmtc_pkg.sv
design/rmtc_rot_cell.sv
design/rmtc_vec_cell.sv
design/rmtc_div_cell.sv
design/relative_motion_true_course_solver_unit.sv
design/rmtc_checker.sv
dv/testbench.sv
